// ----- sv/vbs_pkg.sv -----
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared widths, codes and types of the vertical bicubic strip scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package vbs_pkg;

    localparam int MAX_TAPS   = 16;
    localparam int TAP_CAP    = (MAX_TAPS < 31) ? MAX_TAPS : 31;
    localparam int TAP_AW     = $clog2(TAP_CAP);

    localparam int TAPS_W     = 5;
    localparam int PHASE_W    = 16;
    localparam int FMT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SAMPLE_W   = 32;
    localparam int PIXEL_W    = 32;
    localparam int CHANNELS   = 4;
    localparam int BYTE_W     = 8;

    localparam int WEIGHT_W   = 32;
    localparam int PROD_W     = WEIGHT_W + BYTE_W + 1;
    localparam int SUM_W      = 44;

    localparam int K_W        = 8;
    localparam int OFF_W      = K_W + PHASE_W;
    localparam int D_W        = 20;
    localparam int X_W        = 64;
    localparam int T4_W       = 4 * TAPS_W;
    localparam int QUO_W      = 31;
    localparam int DIV_W      = QUO_W + T4_W;
    localparam int NUM_SHIFT  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd2;

    localparam logic [FMT_W-1:0] FMT_SINGLE = 2'd0;
    localparam logic [FMT_W-1:0] FMT_QUAD   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_TRIPLE = 2'd2;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 5'd4;
    localparam logic [TAPS_W-1:0] TAPS_MIN   = 5'd4;

    localparam logic [SUM_W:0] ROUND_BIAS = 45'((64'd1 << 29) + 64'd8192);
    localparam logic [SUM_W:0] SAT_LIMIT  = 45'(64'd1 << 38);

    typedef struct packed {
        logic                 we;
        logic [TAP_AW-1:0]    addr;
        logic [WEIGHT_W-1:0]  data;
    } t_wgt_wr;

endpackage

`default_nettype wire

// ----- sv/vbs_in_if.sv -----
// ----------------------------------------------------------------------------
// vbs_in_if
// Input channel: one strip-row sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbs_in_if;
    logic                          valid;
    logic                          ready;
    logic [vbs_pkg::SAMPLE_W-1:0]  sample;
    logic                          end_of_row;

    modport source (output valid, output sample, output end_of_row, input ready);
    modport sink   (input valid, input sample, input end_of_row, output ready);
endinterface

`default_nettype wire

// ----- sv/vbs_out_if.sv -----
// ----------------------------------------------------------------------------
// vbs_out_if
// Output channel: one resampled pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbs_out_if;
    logic                         valid;
    logic                         ready;
    logic [vbs_pkg::PIXEL_W-1:0]  pixel;
    logic                         row_done;

    modport source (output valid, output pixel, output row_done, input ready);
    modport sink   (input valid, input pixel, input row_done, output ready);
endinterface

`default_nettype wire

// ----- sv/vbs_ram.sv -----
// ----------------------------------------------------------------------------
// vbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/vbs_weight_gen.sv -----
// ----------------------------------------------------------------------------
// vbs_weight_gen
// Sweeps the tap table and writes one Catmull-Rom Q1.30 weight per entry,
// using Horner evaluation on a shared multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_weight_gen (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [vbs_pkg::TAPS_W-1:0]    i_taps,
    input  wire logic [vbs_pkg::PHASE_W-1:0]   i_phase,
    output      logic                          o_busy,
    output      vbs_pkg::t_wgt_wr              o_wr
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_LOAD = 12'b000000000010,
        S_T2   = 12'b000000000100,
        S_T3   = 12'b000000001000,
        S_T4   = 12'b000000010000,
        S_DIST = 12'b000000100000,
        S_MLO  = 12'b000001000000,
        S_MHI  = 12'b000010000000,
        S_ADD  = 12'b000100000000,
        S_DSET = 12'b001000000000,
        S_DIV  = 12'b010000000000,
        S_WR   = 12'b100000000000
    } t_wg_state;

    t_wg_state                             r_state;
    logic [vbs_pkg::TAP_AW-1:0]            r_entry;
    logic [vbs_pkg::TAPS_W-1:0]            r_t;
    logic [2*vbs_pkg::TAPS_W-1:0]          r_t2;
    logic [3*vbs_pkg::TAPS_W-1:0]          r_t3;
    logic [vbs_pkg::T4_W-1:0]              r_t4;
    logic                                  r_neg;
    logic                                  r_step;
    logic [vbs_pkg::D_W-1:0]               r_d;
    logic [vbs_pkg::X_W-1:0]               r_x;
    logic signed [53:0]                    r_plo;
    logic signed [53:0]                    r_phi;
    logic [vbs_pkg::T4_W-1:0]              r_rem;
    logic [vbs_pkg::QUO_W-1:0]             r_quo;
    logic [4:0]                            r_cnt;
    vbs_pkg::t_wgt_wr                      r_wr;

    logic [vbs_pkg::K_W-1:0]               dist_k;
    logic [vbs_pkg::OFF_W-1:0]             dist_off;
    logic [vbs_pkg::OFF_W-1:0]             dist_mag;
    logic                                  dist_far;
    logic                                  dist_neg;
    logic [vbs_pkg::X_W-1:0]               d64;
    logic [vbs_pkg::X_W-1:0]               t64;
    logic [vbs_pkg::X_W-1:0]               x0;
    logic signed [32:0]                    mul_a;
    logic signed [20:0]                    mul_b;
    logic signed [53:0]                    mul_p;
    logic [vbs_pkg::X_W-1:0]               cterm;
    logic [vbs_pkg::X_W-1:0]               x_sum;
    logic [vbs_pkg::DIV_W-1:0]             div_d;
    logic [vbs_pkg::T4_W:0]                trial;
    logic [vbs_pkg::T4_W:0]                diff;
    logic                                  ge;
    logic [vbs_pkg::WEIGHT_W-1:0]          w_pos;

    always_comb begin
        dist_k   = vbs_pkg::K_W'(r_entry) + vbs_pkg::K_W'(1)
                   - vbs_pkg::K_W'(r_t[vbs_pkg::TAPS_W-1:1]);
        dist_off = {dist_k, {vbs_pkg::PHASE_W{1'b0}}} - vbs_pkg::OFF_W'(i_phase);
        dist_mag = dist_off[vbs_pkg::OFF_W-1] ? (~dist_off + 1'b1) : dist_off;
        dist_far = dist_mag >= vbs_pkg::OFF_W'({r_t, 15'b0});
        dist_neg = dist_mag >= vbs_pkg::OFF_W'({r_t, 14'b0});
        d64      = vbs_pkg::X_W'(dist_mag[vbs_pkg::D_W-1:0]);
        t64      = vbs_pkg::X_W'({r_t, 14'b0});
        x0       = (dist_neg ? d64 : d64 + (d64 << 1)) - (t64 + (t64 << 2));
    end

    always_comb begin
        mul_a = (r_state == S_MHI) ? $signed({r_x[63], r_x[63:32]})
                                   : $signed({1'b0, r_x[31:0]});
        mul_b = $signed({1'b0, r_d});
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        if (!r_step) begin
            cterm = r_neg ? vbs_pkg::X_W'({r_t2, 31'b0}) : '0;
        end else begin
            cterm = r_neg ? (~vbs_pkg::X_W'({r_t3, 44'b0}) + 1'b1)
                          : vbs_pkg::X_W'({r_t3, 43'b0});
        end
        x_sum = {r_phi[31:0], 32'b0} + vbs_pkg::X_W'(unsigned'(r_plo)) + cterm;
    end

    always_comb begin
        div_d = r_x[vbs_pkg::NUM_SHIFT +: vbs_pkg::DIV_W];
        trial = {r_rem, r_quo[vbs_pkg::QUO_W-1]};
        ge    = trial >= {1'b0, r_t4};
        diff  = trial - {1'b0, r_t4};
        w_pos = {1'b0, r_quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_entry <= '0;
            r_wr.we <= 1'b0;
        end else begin
            r_wr.we <= 1'b0;
            if (i_start) begin
                r_state <= S_LOAD;
                r_entry <= '0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        r_state <= S_IDLE;
                    end
                    S_LOAD: begin
                        r_state <= S_T2;
                    end
                    S_T2: begin
                        r_state <= S_T3;
                    end
                    S_T3: begin
                        r_state <= S_T4;
                    end
                    S_T4: begin
                        r_state <= S_DIST;
                    end
                    S_DIST: begin
                        r_state <= dist_far ? S_WR : S_MLO;
                    end
                    S_MLO: begin
                        r_state <= S_MHI;
                    end
                    S_MHI: begin
                        r_state <= S_ADD;
                    end
                    S_ADD: begin
                        r_state <= r_step ? S_DSET : S_MLO;
                    end
                    S_DSET: begin
                        r_state <= S_DIV;
                    end
                    S_DIV: begin
                        if (r_cnt == 5'(vbs_pkg::QUO_W - 1)) begin
                            r_state <= S_WR;
                        end
                    end
                    S_WR: begin
                        r_wr.we <= 1'b1;
                        if (r_entry == vbs_pkg::TAP_AW'(vbs_pkg::TAP_CAP - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_entry <= r_entry + 1'b1;
                            r_state <= S_DIST;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_t <= i_taps;
            end
            S_T2: begin
                r_t2 <= r_t * r_t;
            end
            S_T3: begin
                r_t3 <= r_t2 * r_t;
            end
            S_T4: begin
                r_t4 <= r_t3 * r_t;
            end
            S_DIST: begin
                r_d    <= dist_mag[vbs_pkg::D_W-1:0];
                r_x    <= x0;
                r_step <= 1'b0;
                r_neg  <= dist_far ? 1'b0 : dist_neg;
                r_quo  <= '0;
            end
            S_MLO: begin
                r_plo <= mul_p;
            end
            S_MHI: begin
                r_phi <= mul_p;
            end
            S_ADD: begin
                r_x    <= x_sum;
                r_step <= 1'b1;
            end
            S_DSET: begin
                r_rem <= div_d[vbs_pkg::DIV_W-1:vbs_pkg::QUO_W];
                r_quo <= div_d[vbs_pkg::QUO_W-1:0];
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= ge ? diff[vbs_pkg::T4_W-1:0] : trial[vbs_pkg::T4_W-1:0];
                r_quo <= {r_quo[vbs_pkg::QUO_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_WR: begin
                r_wr.addr <= r_entry;
                r_wr.data <= r_neg ? (~w_pos + 1'b1) : w_pos;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE) || r_wr.we;
    assign o_wr   = r_wr;

endmodule

`default_nettype wire

// ----- sv/vertical_bicubic_strip_scaler.sv -----
// ----------------------------------------------------------------------------
// vertical_bicubic_strip_scaler
// Vertical Catmull-Rom resampler producing one output scanline pixel per
// column from tap_count strip-row samples.
//
// Usage: i_px carries one strip-row sample per beat, rows in order, taps
// beats per column; o_px carries one packed pixel per column, with row_done
// set when any beat of that column had end_of_row. The config port writes
// tap_count (0), phase (1) and pixel_format (2); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Throughput: one beat per cycle within a column. The last beat of a column
// is held off until the previous pixel has left the rounding stage. A pixel
// passes the weight RAM read, multiply, accumulate, and round and clamp
// registers before it is valid. Reset, and each write of tap_count or phase,
// starts a sweep that rebuilds the weight RAM on one shared multiplier and
// divider; during the sweep i_px.ready is low. When the receiver stalls, the
// pixel holds on o_px and one more finished column waits in the rounding
// stage; taps of the following column still flow until its last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_bicubic_strip_scaler (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [vbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [vbs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    vbs_in_if.sink                                 i_px,
    vbs_out_if.source                              o_px
);

    logic [vbs_pkg::TAPS_W-1:0]             r_tap_count;
    logic [vbs_pkg::PHASE_W-1:0]            r_phase;
    logic [vbs_pkg::FMT_W-1:0]              r_pixel_format;
    logic [vbs_pkg::TAP_AW-1:0]             r_tap_index;
    logic                                   r_row_end_seen;
    logic signed [vbs_pkg::SUM_W-1:0]       r_sum [vbs_pkg::CHANNELS];

    logic                                   r_s1_v;
    logic [vbs_pkg::SAMPLE_W-1:0]           r_s1_smp;
    logic                                   r_s1_last;
    logic                                   r_s1_eor;

    logic                                   r_s2_v;
    logic signed [vbs_pkg::PROD_W-1:0]      r_s2_prod [vbs_pkg::CHANNELS];
    logic                                   r_s2_last;
    logic                                   r_s2_eor;

    logic                                   r_fin_v;
    logic signed [vbs_pkg::SUM_W-1:0]       r_fin_sum [vbs_pkg::CHANNELS];
    logic                                   r_fin_eor;

    logic                                   r_out_valid;
    logic [vbs_pkg::PIXEL_W-1:0]            r_out_pixel;
    logic                                   r_out_row_done;

    logic [vbs_pkg::TAPS_W-1:0]             taps;
    logic [vbs_pkg::TAP_AW-1:0]             idx_eff;
    logic                                   last_now;
    logic                                   pend;
    logic                                   accept;
    logic                                   fin_move;
    logic                                   wg_start;
    logic                                   wg_busy;
    vbs_pkg::t_wgt_wr                       wg_wr;
    logic [vbs_pkg::WEIGHT_W-1:0]           w_rd;
    logic [vbs_pkg::TAP_AW-1:0]             n_tap_index;
    logic signed [vbs_pkg::SUM_W-1:0]       n_sum [vbs_pkg::CHANNELS];
    logic [vbs_pkg::PIXEL_W-1:0]            n_pixel;

    function automatic logic [vbs_pkg::TAPS_W-1:0] eff_taps(
        input logic [vbs_pkg::TAPS_W-1:0] tc
    );
        logic [vbs_pkg::TAPS_W-1:0] t;
        t = tc;
        if (t < vbs_pkg::TAPS_MIN) begin
            t = vbs_pkg::TAPS_MIN;
        end
        if (t > vbs_pkg::TAPS_W'(vbs_pkg::TAP_CAP)) begin
            t = vbs_pkg::TAPS_W'(vbs_pkg::TAP_CAP);
        end
        return t;
    endfunction

    function automatic logic [vbs_pkg::BYTE_W-1:0] round_clamp(
        input logic signed [vbs_pkg::SUM_W-1:0] s
    );
        logic [vbs_pkg::SUM_W:0] v;
        v = {s[vbs_pkg::SUM_W-1], s} + vbs_pkg::ROUND_BIAS;
        if (s[vbs_pkg::SUM_W-1]) begin
            return '0;
        end else if (v >= vbs_pkg::SAT_LIMIT) begin
            return '1;
        end
        return v[37:30];
    endfunction

    // config
    assign wg_start = i_cfg_we && ((i_cfg_idx == vbs_pkg::CFG_TAP_COUNT)
                                || (i_cfg_idx == vbs_pkg::CFG_PHASE));

    vbs_weight_gen u_weight_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wg_start),
        .i_taps  (eff_taps(r_tap_count)),
        .i_phase (r_phase),
        .o_busy  (wg_busy),
        .o_wr    (wg_wr)
    );

    vbs_ram #(
        .WIDTH (vbs_pkg::WEIGHT_W),
        .DEPTH (vbs_pkg::TAP_CAP)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wg_wr.we),
        .i_waddr (wg_wr.addr),
        .i_wdata (wg_wr.data),
        .i_raddr (idx_eff),
        .o_rdata (w_rd)
    );

    always_comb begin
        taps     = eff_taps(r_tap_count);
        idx_eff  = (vbs_pkg::TAPS_W'(r_tap_index) >= taps)
                   ? vbs_pkg::TAP_AW'(taps - 1'b1) : r_tap_index;
        last_now = (vbs_pkg::TAPS_W'(idx_eff) + 1'b1) == taps;
        pend     = (r_s1_v && r_s1_last) || (r_s2_v && r_s2_last) || r_fin_v;
        n_tap_index = last_now ? '0 : idx_eff + 1'b1;
    end

    assign i_px.ready = !wg_busy && !(last_now && pend);
    assign accept     = i_px.valid && i_px.ready;
    assign fin_move   = r_fin_v && (!r_out_valid || o_px.ready);

    always_comb begin
        for (int c = 0; c < vbs_pkg::CHANNELS; c++) begin
            n_sum[c] = r_sum[c] + vbs_pkg::SUM_W'(r_s2_prod[c]);
        end
    end

    always_comb begin
        n_pixel = '0;
        n_pixel[7:0] = round_clamp(r_fin_sum[0]);
        if ((r_pixel_format == vbs_pkg::FMT_QUAD)
            || (r_pixel_format == vbs_pkg::FMT_TRIPLE)) begin
            n_pixel[15:8]  = round_clamp(r_fin_sum[1]);
            n_pixel[23:16] = round_clamp(r_fin_sum[2]);
        end
        if (r_pixel_format == vbs_pkg::FMT_QUAD) begin
            n_pixel[31:24] = round_clamp(r_fin_sum[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count    <= vbs_pkg::TAPS_RESET;
            r_phase        <= '0;
            r_pixel_format <= vbs_pkg::FMT_QUAD;
            r_tap_index    <= '0;
            r_row_end_seen <= 1'b0;
            r_s1_v         <= 1'b0;
            r_s2_v         <= 1'b0;
            r_fin_v        <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int c = 0; c < vbs_pkg::CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vbs_pkg::CFG_TAP_COUNT: begin
                        r_tap_count <= i_cfg_data[vbs_pkg::TAPS_W-1:0];
                    end
                    vbs_pkg::CFG_PHASE: begin
                        r_phase <= i_cfg_data;
                    end
                    vbs_pkg::CFG_PIXEL_FORMAT: begin
                        r_pixel_format <= i_cfg_data[vbs_pkg::FMT_W-1:0];
                    end
                    default: begin
                        r_phase <= r_phase;
                    end
                endcase
            end

            if (accept) begin
                r_tap_index <= n_tap_index;
            end
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;

            // accumulate, clear after the last tap of a column
            if (r_s2_v) begin
                if (r_s2_last) begin
                    r_row_end_seen <= 1'b0;
                    for (int c = 0; c < vbs_pkg::CHANNELS; c++) begin
                        r_sum[c] <= '0;
                    end
                end else begin
                    r_row_end_seen <= r_row_end_seen || r_s2_eor;
                    for (int c = 0; c < vbs_pkg::CHANNELS; c++) begin
                        r_sum[c] <= n_sum[c];
                    end
                end
            end

            if (r_s2_v && r_s2_last) begin
                r_fin_v <= 1'b1;
            end else if (fin_move) begin
                r_fin_v <= 1'b0;
            end

            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (o_px.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_smp  <= i_px.sample;
            r_s1_last <= last_now;
            r_s1_eor  <= i_px.end_of_row;
        end
        if (r_s1_v) begin
            r_s2_last <= r_s1_last;
            r_s2_eor  <= r_s1_eor;
            for (int c = 0; c < vbs_pkg::CHANNELS; c++) begin
                r_s2_prod[c] <= $signed(w_rd)
                              * $signed({1'b0, r_s1_smp[c*vbs_pkg::BYTE_W +: vbs_pkg::BYTE_W]});
            end
        end
        if (r_s2_v && r_s2_last) begin
            r_fin_eor <= r_row_end_seen || r_s2_eor;
            for (int c = 0; c < vbs_pkg::CHANNELS; c++) begin
                r_fin_sum[c] <= n_sum[c];
            end
        end
        if (fin_move) begin
            r_out_pixel    <= n_pixel;
            r_out_row_done <= r_fin_eor;
        end
    end

    assign o_px.valid    = r_out_valid;
    assign o_px.pixel    = r_out_pixel;
    assign o_px.row_done = r_out_row_done;

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_fin_v))
        else $error("pixel beat raised without a finished column");

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2_last) |-> !r_fin_v)
        else $error("column end reached an occupied rounding stage");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_v && r_out_valid && !o_px.ready) |=> r_fin_v)
        else $error("finished column dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ----- dv/vbs_resample_check.sv -----
// ----------------------------------------------------------------------------
// vbs_resample_check
// Watches the sample and pixel channels of the vertical bicubic strip scaler.
// Tracks the register writes, works out the Catmull-Rom tap weights in exact
// integer arithmetic, and accumulates each accepted sample beat per channel.
// The finished pixel of each column is queued, and every pixel beat is
// compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_resample_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [vbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [vbs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    vbs_in_if                                      in_ch,
    vbs_out_if                                     out_ch,
    output int                                     o_fail_count = 0,
    output int                                     o_pending = 0
);
    timeunit 1ns;
    timeprecision 1ps;

    import vbs_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               row_done;
    } pixel_t;

    pixel_t              pixels_due[$];

    logic [TAPS_W-1:0]   tap_count_r;
    logic [PHASE_W-1:0]  phase_r;
    logic [FMT_W-1:0]    format_r;
    int unsigned         tap_pos;
    longint              chan_sum [CHANNELS];
    logic                row_end_held;

    function automatic int unsigned effective_taps();
        int unsigned t;
        t = tap_count_r;
        if (t < TAPS_MIN) t = TAPS_MIN;
        if (t > MAX_TAPS) t = MAX_TAPS;
        return t;
    endfunction

    // Exact Catmull-Rom weight in Q1.30, truncated toward zero
    function automatic longint tap_weight_q30(input int unsigned taps, input int unsigned idx,
                                              input logic [PHASE_W-1:0] ph);
        longint      k;
        longint      off;
        bit [63:0]   d;
        bit [63:0]   span;
        bit [63:0]   den;
        bit [63:0]   mag;
        k    = longint'(idx) + 1 - longint'(taps / 2);
        off  = k * 65536 - longint'(ph);
        d    = (off < 0) ? 64'(-off) : 64'(off);
        span = 64'(taps) * 64'd16384;
        den  = 64'd2048 * 64'(taps) * 64'(taps) * 64'(taps) * 64'(taps);
        if (d >= 2 * span) return 0;
        if (d < span) begin
            mag = (3 * d * d * d + 2 * span * span * span) - 5 * d * d * span;
            return longint'(mag / den);
        end
        mag = (d * d * d + 8 * d * span * span) - (5 * d * d * span + 4 * span * span * span);
        return -longint'(mag / den);
    endfunction

    function automatic logic [BYTE_W-1:0] clamp_channel(input longint s);
        longint v;
        if (s < 0) return '0;
        v = s + (longint'(1) << 29) + 8192;
        if (v >= (longint'(1) << 38)) return 8'hFF;
        return 8'(v >>> 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < PRINT_CAP)
            $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic accumulate_tap(input logic [SAMPLE_W-1:0] smp, input logic eor);
        int unsigned         taps;
        longint              w;
        logic [PIXEL_W-1:0]  px;
        pixel_t              done_px;
        taps = effective_taps();
        if (tap_pos >= taps) tap_pos = taps - 1;
        w = tap_weight_q30(taps, tap_pos, phase_r);
        for (int c = 0; c < CHANNELS; c++)
            chan_sum[c] += w * longint'({56'd0, smp[BYTE_W*c +: BYTE_W]});
        if (eor) row_end_held = 1'b1;
        if (tap_pos + 1 < taps) begin
            tap_pos++;
            return;
        end
        px = '0;
        px[7:0] = clamp_channel(chan_sum[0]);
        if (format_r == FMT_QUAD || format_r == FMT_TRIPLE) begin
            px[15:8]  = clamp_channel(chan_sum[1]);
            px[23:16] = clamp_channel(chan_sum[2]);
        end
        if (format_r == FMT_QUAD) px[31:24] = clamp_channel(chan_sum[3]);
        done_px.pixel    = px;
        done_px.row_done = row_end_held;
        pixels_due.push_back(done_px);
        tap_pos      = 0;
        row_end_held = 1'b0;
        for (int c = 0; c < CHANNELS; c++) chan_sum[c] = 0;
    endtask

    task automatic check_pixel(input logic [PIXEL_W-1:0] px, input logic rd);
        pixel_t want;
        if (pixels_due.size() == 0) begin
            report_mismatch("pixel with none due", px, '0);
            return;
        end
        want = pixels_due.pop_front();
        if (px !== want.pixel) report_mismatch("pixel", px, want.pixel);
        if (rd !== want.row_done) report_mismatch("row_done", 32'(rd), 32'(want.row_done));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tap_count_r  = TAPS_RESET;
            phase_r      = '0;
            format_r     = FMT_QUAD;
            tap_pos      = 0;
            row_end_held = 1'b0;
            for (int c = 0; c < CHANNELS; c++) chan_sum[c] = 0;
            pixels_due.delete();
            o_fail_count = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_pixel(out_ch.pixel, out_ch.row_done);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TAP_COUNT:    tap_count_r = i_cfg_data[TAPS_W-1:0];
                    CFG_PHASE:        phase_r     = i_cfg_data[PHASE_W-1:0];
                    CFG_PIXEL_FORMAT: format_r    = i_cfg_data[FMT_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) accumulate_tap(in_ch.sample, in_ch.end_of_row);
        end
        o_pending = pixels_due.size();
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the vertical bicubic strip scaler bench.
// Drives whole columns of strip-row samples under a series of register
// settings (reset values, extreme phases, every pixel format, odd and
// out-of-range tap counts), with random idling on both channels. The
// resample check beside the block predicts and compares; this top only
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vbs_pkg::*;

    localparam int LIMIT_CYCLES = 250000;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 16;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASES       = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [FMT_W-1:0]     FMT_SPARE = 2'd3;

    localparam logic [SAMPLE_W-1:0] DIRECTED [24] = '{
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'h00000000, 32'hA55A0FF0, 32'h00000000, 32'h00000000,
        32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
        32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'hFFFFFFFF,
        32'h00FF00FF, 32'hFF00FF00, 32'hFF00FF00, 32'h00FF00FF,
        32'h80808080, 32'h7F7F7F7F, 32'h01010101, 32'hFEFEFEFE
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pixels_owed;
    int                    cycle_count = 0;
    bit                    calm = 1'b0;

    vbs_in_if  in_ch();
    vbs_out_if out_ch();

    always #6 i_clk = ~i_clk;

    vertical_bicubic_strip_scaler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_px       (in_ch),
        .o_px       (out_ch)
    );

    vbs_resample_check resample_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pixels_owed)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        out_ch.ready <= calm || ($urandom_range(99) >= 18);

    function automatic int unsigned active_taps(input logic [TAPS_W-1:0] tc);
        if (tc < TAPS_MIN) return TAPS_MIN;
        if (tc > MAX_TAPS) return MAX_TAPS;
        return tc;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] s;
        logic [BYTE_W-1:0]   base;
        base = 8'($urandom);
        case ($urandom_range(3))
            0: s = $urandom;
            1: for (int c = 0; c < CHANNELS; c++)
                   s[BYTE_W*c +: BYTE_W] = $urandom_range(1) ? 8'hFF : 8'h00;
            2: for (int c = 0; c < CHANNELS; c++)
                   s[BYTE_W*c +: BYTE_W] = base + 8'($urandom_range(7));
            default: s = {CHANNELS{base}};
        endcase
        return s;
    endfunction

    // Entered and left at a falling edge, with nothing yet assigned in that step
    task automatic drive_beat(input logic [SAMPLE_W-1:0] smp, input logic eor);
        while (!calm && $urandom_range(99) < 18) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample     <= smp;
        in_ch.end_of_row <= eor;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drive_column(input int unsigned taps, input bit last_of_row);
        int unsigned mark;
        logic        eor;
        mark = $urandom_range(taps - 1);
        for (int unsigned t = 0; t < taps; t++) begin
            eor = last_of_row ? (t == mark || $urandom_range(3) == 0) : ($urandom_range(49) == 0);
            drive_beat(pick_sample(), eor);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pixels_owed != 0);
    endtask

    // Hold off until the weight sweep has finished
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        repeat (SETTLE) @(negedge i_clk);
        while (!in_ch.ready) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [TAPS_W-1:0] tc, input logic [PHASE_W-1:0] ph,
                                 input logic [FMT_W-1:0] fmt);
        drain_results();
        write_reg(CFG_TAP_COUNT, {11'($urandom), tc});
        write_reg(CFG_PHASE, ph);
        write_reg(CFG_PIXEL_FORMAT, {14'($urandom), fmt});
    endtask

    initial begin
        logic [TAPS_W-1:0]  tc;
        logic [PHASE_W-1:0] ph;
        logic [FMT_W-1:0]   fmt;
        int unsigned        taps;
        int unsigned        cols;
        int unsigned        left;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.sample     = '0;
        in_ch.end_of_row = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 24; i++) begin
            if (i == 8) apply_setting(5'd4, 16'h8000, FMT_QUAD);
            drive_beat(DIRECTED[i], i == 7 || i == 23);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin tc = 5'd16; ph = 16'h0000; fmt = FMT_SINGLE; end
                1: begin tc = 5'd16; ph = 16'hFFFF; fmt = FMT_TRIPLE; end
                2: begin tc = 5'd4;  ph = 16'hFFFF; fmt = FMT_SPARE;  end
                3: begin tc = 5'd0;  ph = 16'h0001; fmt = FMT_QUAD;   end
                4: begin tc = 5'd31; ph = $urandom; fmt = FMT_TRIPLE; end
                5: begin tc = 5'd5;  ph = $urandom; fmt = FMT_QUAD;   end
                6: begin tc = 5'd15; ph = $urandom; fmt = FMT_SINGLE; end
                default: begin
                    tc  = ($urandom_range(9) < 7) ? 5'($urandom_range(4, 16)) : 5'($urandom);
                    ph  = $urandom;
                    fmt = $urandom;
                end
            endcase
            calm = (p == 3 || p == 4);
            apply_setting(tc, ph, fmt);
            if (p == 5) write_reg(CFG_SPARE, 16'($urandom));
            taps = active_taps(tc);
            cols = (PHASE_ITEMS + taps - 1) / taps;
            left = $urandom_range(1, 6);
            for (int c = 0; c < cols; c++) begin
                if (p == 6 && c == cols / 2) drain_results();
                left--;
                drive_column(taps, left == 0 || c == cols - 1);
                if (left == 0) left = $urandom_range(1, 6);
            end
        end

        drain_results();
        repeat (TAIL) @(negedge i_clk);
        if (fail_count == 0 && pixels_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/vbs_pkg.sv
sv/vbs_in_if.sv
sv/vbs_out_if.sv
sv/vbs_ram.sv
sv/vbs_weight_gen.sv
sv/vertical_bicubic_strip_scaler.sv
dv/vbs_resample_check.sv
dv/tb.sv
